// ===== hdl/irpcm_pkg.sv =====
// Shared types and constants of the IR pulse capture and match unit.
// Used by the front end, the event queue, the compare back end and the top level.
// No dependencies.
`default_nettype none

package irpcm_pkg;

    // Configuration port geometry and register indexes.
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 15;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_RELEASE_TIME = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_TOLERANCE    = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_REF_LENGTH   = 2'd2;

    // Field widths fixed by the interface.
    localparam int RELEASE_BITS   = 15;
    localparam int TOL_BITS       = 8;
    localparam int LEN_BITS       = 8;
    localparam int REF_INDEX_BITS = 7;
    localparam int REF_DUR_BITS   = 15;
    localparam int COUNT_BITS     = 8;
    localparam int IN_DATA_BITS   = 24;
    localparam int OUT_DATA_BITS  = 16;

    // Register values after reset.
    localparam logic [RELEASE_BITS-1:0] RELEASE_RESET = 15'd10000;
    localparam logic [TOL_BITS-1:0]     TOL_RESET     = 8'd25;
    localparam logic [LEN_BITS-1:0]     LEN_RESET     = 8'd0;

    // Tolerance is given in percent of the measured duration.
    localparam int PCT_DIVISOR = 100;

    // Entries in the queue between front end and back end.
    localparam int QUEUE_DEPTH = 4;

    // What one queue entry asks the back end to do. A compare and a frame end
    // may come together in one entry.
    typedef struct packed {
        logic wr;   // store a reference entry
        logic cmp;  // compare a finished duration against the table
        logic fin;  // frame end: emit a result
        logic ovf;  // overflow flag of the finished frame
    } irpcm_op_t;

endpackage

`default_nettype wire

// ===== hdl/irpcm_front.sv =====
// Front end: times high and low durations of the IR level and emits table
// writes, duration compares and frame ends as queue entries.
// Depends on irpcm_pkg.
`default_nettype none

module irpcm_front
    import irpcm_pkg::*;
#(
    parameter int MAX_PULSES    = 128,
    parameter int DURATION_BITS = 15
)(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      accept,
    input  wire logic                      func,
    input  wire logic                      level,
    input  wire logic [REF_INDEX_BITS-1:0] ref_index,
    input  wire logic [REF_DUR_BITS-1:0]   ref_duration,
    input  wire logic [RELEASE_BITS-1:0]   release_time,
    input  wire logic [LEN_BITS-1:0]       reference_length,
    output logic                           push,
    output irpcm_op_t                      push_op,
    output logic [$clog2(MAX_PULSES)-1:0]  push_idx,
    output logic [DURATION_BITS-1:0]       push_val,
    output logic [COUNT_BITS-1:0]          push_cnt
);

    localparam int IW = $clog2(MAX_PULSES);
    localparam int CW = $clog2(MAX_PULSES + 1);
    localparam int DB = DURATION_BITS;

    localparam logic [1:0] PH_START   = 2'd0;
    localparam logic [1:0] PH_HIGH    = 2'd1;
    localparam logic [1:0] PH_LOW     = 2'd2;
    localparam logic [1:0] PH_WAITLOW = 2'd3;

    logic [1:0]    phase_reg, phase_next;
    logic [DB-1:0] elapsed_reg, elapsed_next;
    logic [CW-1:0] count_reg, count_next;
    logic          ovf_reg, ovf_next;

    // Next state of the timer and the entry that this beat produces.
    always_comb
    begin
        logic          rec;
        logic [DB-1:0] rec_m;
        logic          hi_tick;
        logic [DB-1:0] hi_base;
        logic [DB:0]   hi_sum;
        logic [DB:0]   lo_sum;
        logic [COUNT_BITS-1:0] idx_wide;

        rec          = 1'b0;
        rec_m        = elapsed_reg;
        hi_tick      = 1'b0;
        hi_base      = elapsed_reg;
        hi_sum       = '0;
        lo_sum       = {1'b0, elapsed_reg} + {{DB{1'b0}}, 1'b1};
        idx_wide     = COUNT_BITS'(ref_index);

        phase_next   = phase_reg;
        elapsed_next = elapsed_reg;
        count_next   = count_reg;
        ovf_next     = ovf_reg;
        push_op      = '0;
        push_idx     = count_reg[IW-1:0];
        push_val     = elapsed_reg;
        push_cnt     = '0;

        if (func)
        begin
            // Table write beat: timing does not advance.
            push_op.wr = (idx_wide < COUNT_BITS'(MAX_PULSES));
            push_idx   = idx_wide[IW-1:0];
            push_val   = DB'(ref_duration);
        end
        else
        begin
            unique case (phase_reg)
                PH_START:
                begin
                    if (level)
                    begin
                        count_next = '0;
                        ovf_next   = 1'b0;
                        hi_tick    = 1'b1;
                        hi_base    = '0;
                        phase_next = PH_HIGH;
                    end
                end
                PH_HIGH:
                begin
                    if (level)
                    begin
                        hi_tick = 1'b1;
                    end
                    else
                    begin
                        rec          = 1'b1;
                        elapsed_next = {{(DB-1){1'b0}}, 1'b1};
                        phase_next   = PH_LOW;
                    end
                end
                PH_LOW:
                begin
                    if (level)
                    begin
                        rec        = 1'b1;
                        hi_tick    = 1'b1;
                        hi_base    = '0;
                        phase_next = PH_HIGH;
                    end
                    else
                    begin
                        elapsed_next = lo_sum[DB] ? {DB{1'b1}} : lo_sum[DB-1:0];
                    end
                end
                PH_WAITLOW:
                begin
                    if (!level)
                    begin
                        phase_next = PH_START;
                    end
                end
                default:
                begin
                    phase_next = PH_START;
                end
            endcase

            // A finished duration: compare it while within the reference length; on a full table flag overflow.
            if (rec)
            begin
                if (count_reg >= CW'(MAX_PULSES))
                begin
                    ovf_next = 1'b1;
                end
                else
                begin
                    push_op.cmp = (COUNT_BITS'(count_reg) < reference_length);
                    push_val    = rec_m;
                    count_next  = count_reg + CW'(1);
                end
            end

            // One more high tick; a high longer than the release time ends the frame.
            if (hi_tick)
            begin
                hi_sum       = {1'b0, hi_base} + {{DB{1'b0}}, 1'b1};
                elapsed_next = hi_sum[DB] ? {DB{1'b1}} : hi_sum[DB-1:0];
                if (32'(hi_sum) > 32'(release_time))
                begin
                    push_op.fin  = 1'b1;
                    push_op.ovf  = ovf_next;
                    push_cnt     = COUNT_BITS'(count_next);
                    phase_next   = PH_WAITLOW;
                    elapsed_next = '0;
                end
            end
        end

        push = accept && (push_op.wr || push_op.cmp || push_op.fin);
    end

    // Timer state registers, advanced on every tick beat.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_START;
            elapsed_reg <= '0;
            count_reg   <= '0;
            ovf_reg     <= 1'b0;
        end
        else if (accept && !func)
        begin
            phase_reg   <= phase_next;
            elapsed_reg <= elapsed_next;
            count_reg   <= count_next;
            ovf_reg     <= ovf_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/irpcm_queue.sv =====
// Short first-in first-out queue of back-end entries between the front end
// and the compare back end. Depends on irpcm_pkg.
`default_nettype none

module irpcm_queue
    import irpcm_pkg::*;
#(
    parameter int IDX_BITS      = 7,
    parameter int DURATION_BITS = 15
)(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     push,
    input  wire irpcm_op_t                push_op,
    input  wire logic [IDX_BITS-1:0]      push_idx,
    input  wire logic [DURATION_BITS-1:0] push_val,
    input  wire logic [COUNT_BITS-1:0]    push_cnt,
    input  wire logic                     pop,
    output irpcm_op_t                     pop_op,
    output logic [IDX_BITS-1:0]           pop_idx,
    output logic [DURATION_BITS-1:0]      pop_val,
    output logic [COUNT_BITS-1:0]         pop_cnt,
    output logic                          empty,
    output logic                          full
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int FW = $clog2(QUEUE_DEPTH + 1);

    irpcm_op_t                op_q  [QUEUE_DEPTH];
    logic [IDX_BITS-1:0]      idx_q [QUEUE_DEPTH];
    logic [DURATION_BITS-1:0] val_q [QUEUE_DEPTH];
    logic [COUNT_BITS-1:0]    cnt_q [QUEUE_DEPTH];

    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FW-1:0] fill_reg;

    assign empty   = (fill_reg == '0);
    assign full    = (fill_reg == FW'(QUEUE_DEPTH));
    assign pop_op  = op_q[rd_ptr_reg];
    assign pop_idx = idx_q[rd_ptr_reg];
    assign pop_val = val_q[rd_ptr_reg];
    assign pop_cnt = cnt_q[rd_ptr_reg];

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            op_q[wr_ptr_reg]  <= push_op;
            idx_q[wr_ptr_reg] <= push_idx;
            val_q[wr_ptr_reg] <= push_val;
            cnt_q[wr_ptr_reg] <= push_cnt;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + FW'(1);
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - FW'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ===== hdl/irpcm_back.sv =====
// Back end: reference table, tolerance compare pipeline and result register.
// Depends on irpcm_pkg.
`default_nettype none

module irpcm_back
    import irpcm_pkg::*;
#(
    parameter int MAX_PULSES    = 128,
    parameter int DURATION_BITS = 15
)(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          q_empty,
    input  wire irpcm_op_t                     q_op,
    input  wire logic [$clog2(MAX_PULSES)-1:0] q_idx,
    input  wire logic [DURATION_BITS-1:0]      q_val,
    input  wire logic [COUNT_BITS-1:0]         q_cnt,
    output logic                               q_pop,
    input  wire logic [TOL_BITS-1:0]           tolerance_percent,
    input  wire logic [LEN_BITS-1:0]           reference_length,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic                               out_matched,
    output logic [COUNT_BITS-1:0]              out_count,
    output logic                               out_overflowed
);

    localparam int IW = $clog2(MAX_PULSES);
    localparam int DB = DURATION_BITS;
    // Reciprocal of the percent divisor, exact for every DB-bit duration.
    localparam int S  = DB + 7;
    localparam int RW = DB + 1;
    localparam logic [63:0] RECIP_WIDE =
        ((64'd1 << S) + 64'(PCT_DIVISOR - 1)) / 64'(PCT_DIVISOR);
    localparam logic [RW-1:0] RECIP = RECIP_WIDE[RW-1:0];
    localparam int QW = DB - 6;
    localparam int DW = QW + TOL_BITS;
    localparam int SW = ((DB > DW) ? DB : DW) + 1;

    logic adv;

    // Stage 1: table read and quotient.
    logic                  v1_reg;
    irpcm_op_t             op1_reg;
    logic [DB-1:0]         m1_reg;
    logic [QW-1:0]         q1_reg;
    logic [COUNT_BITS-1:0] cnt1_reg;
    logic [DB-1:0]         r1_reg;

    // Stage 2: deviation.
    logic                  v2_reg;
    irpcm_op_t             op2_reg;
    logic [DB-1:0]         m2_reg;
    logic [DW-1:0]         d2_reg;
    logic [COUNT_BITS-1:0] cnt2_reg;
    logic [DB-1:0]         r2_reg;

    logic                  mismatch_reg;
    logic                  out_valid_reg;
    logic                  matched_reg;
    logic [COUNT_BITS-1:0] count_reg;
    logic                  ovf_reg;

    logic [DB-1:0] table_mem [MAX_PULSES];

    logic [2*DB:0] quot_prod;
    logic [SW-1:0] m_ext, d_ext, r_ext, lo_bound, hi_bound;
    logic          cmp_fail, mismatch_now, load_out;

    // The pipeline moves whenever the result register can take a beat.
    assign adv   = !out_valid_reg || out_ready;
    assign q_pop = adv && !q_empty;

    assign quot_prod = (2*DB+1)'(q_val) * (2*DB+1)'(RECIP);

    // Reference table; writes and reads follow queue order.
    always_ff @(posedge clk)
    begin
        if (q_pop && q_op.wr)
        begin
            table_mem[q_idx] <= q_val;
        end
        if (adv)
        begin
            r1_reg <= table_mem[q_idx];
        end
    end

    // Pipeline payload registers.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            op1_reg  <= q_op;
            m1_reg   <= q_val;
            q1_reg   <= quot_prod[S+QW-1:S];
            cnt1_reg <= q_cnt;
            op2_reg  <= op1_reg;
            m2_reg   <= m1_reg;
            d2_reg   <= DW'(q1_reg) * DW'(tolerance_percent);
            cnt2_reg <= cnt1_reg;
            r2_reg   <= r1_reg;
        end
    end

    // Window compare: the entry must lie within the duration plus or minus the deviation.
    always_comb
    begin
        m_ext        = SW'(m2_reg);
        d_ext        = SW'(d2_reg);
        r_ext        = SW'(r2_reg);
        lo_bound     = (m_ext > d_ext) ? (m_ext - d_ext) : '0;
        hi_bound     = m_ext + d_ext;
        cmp_fail     = op2_reg.cmp && ((r_ext < lo_bound) || (r_ext > hi_bound));
        mismatch_now = mismatch_reg || cmp_fail;
        load_out     = adv && v2_reg && op2_reg.fin;
    end

    // Valid bits, mismatch accumulator and result flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            mismatch_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv)
            begin
                v1_reg <= q_pop;
                v2_reg <= v1_reg;
                if (v2_reg)
                begin
                    mismatch_reg <= op2_reg.fin ? 1'b0 : mismatch_now;
                end
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            matched_reg <= !mismatch_now && !op2_reg.ovf && (cnt2_reg == reference_length);
            count_reg   <= cnt2_reg;
            ovf_reg     <= op2_reg.ovf;
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_matched    = matched_reg;
    assign out_count      = count_reg;
    assign out_overflowed = ovf_reg;

endmodule

`default_nettype wire

// ===== hdl/ir_pulse_capture_match_unit.sv =====
// Top level of the IR pulse capture and match unit: configuration registers,
// stream ports, front end, queue and back end. Depends on irpcm_pkg.
`default_nettype none

// The unit takes one input beat every clock cycle while the queue has room: a
// tick beat carries the receiver level of one microsecond, a write beat stores
// one reference duration; the sustained rate is one beat per cycle until the
// queue fills. Table work goes through a four-entry queue into a compare
// pipeline (table read and reciprocal multiply, deviation multiply, window
// compare); a frame result passes the queue, stage 1, stage 2 and the result
// register to the output. A stalled output holds the pipeline; the queue
// absorbs up to four entries, then input is held. The user must ensure
// configuration is written only while the unit is idle; no logic enforces it.
module ir_pulse_capture_match_unit
    import irpcm_pkg::*;
#(
    parameter int MAX_PULSES    = 128,
    parameter int DURATION_BITS = 15
)(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      s_axis_tvalid,
    output logic                           s_axis_tready,
    // Fields from bit 0: level, ref_index[7:1], ref_duration[22:8], zero pad.
    input  wire logic [IN_DATA_BITS-1:0]   s_axis_tdata,
    // Fields from bit 0: func.
    input  wire logic                      s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  wire logic                      m_axis_tready,
    // Fields from bit 0: matched, pulse_count[8:1], overflowed, zero pad.
    output logic [OUT_DATA_BITS-1:0]       m_axis_tdata,
    input  wire logic                      cfg_wr_en,
    input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]  cfg_wr_data
);

    localparam int IW = $clog2(MAX_PULSES);

    logic [RELEASE_BITS-1:0] release_time_reg;
    logic [TOL_BITS-1:0]     tolerance_reg;
    logic [LEN_BITS-1:0]     ref_length_reg;

    logic                     accept;
    logic                     push, pop, q_empty, q_full;
    irpcm_op_t                push_op, pop_op;
    logic [IW-1:0]            push_idx, pop_idx;
    logic [DURATION_BITS-1:0] push_val, pop_val;
    logic [COUNT_BITS-1:0]    push_cnt, pop_cnt;
    logic                     out_matched, out_overflowed;
    logic [COUNT_BITS-1:0]    out_count;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            release_time_reg <= RELEASE_RESET;
            tolerance_reg    <= TOL_RESET;
            ref_length_reg   <= LEN_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_RELEASE_TIME: release_time_reg <= cfg_wr_data[RELEASE_BITS-1:0];
                CFG_TOLERANCE:    tolerance_reg    <= cfg_wr_data[TOL_BITS-1:0];
                CFG_REF_LENGTH:   ref_length_reg   <= cfg_wr_data[LEN_BITS-1:0];
                default:          ;
            endcase
        end
    end

    // An input beat is taken whenever the queue has room.
    assign s_axis_tready = !q_full;
    assign accept        = s_axis_tvalid && s_axis_tready;

    irpcm_front #(
        .MAX_PULSES    (MAX_PULSES),
        .DURATION_BITS (DURATION_BITS)
    ) u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .accept           (accept),
        .func             (s_axis_tuser),
        .level            (s_axis_tdata[0]),
        .ref_index        (s_axis_tdata[REF_INDEX_BITS:1]),
        .ref_duration     (s_axis_tdata[REF_INDEX_BITS+REF_DUR_BITS:REF_INDEX_BITS+1]),
        .release_time     (release_time_reg),
        .reference_length (ref_length_reg),
        .push             (push),
        .push_op          (push_op),
        .push_idx         (push_idx),
        .push_val         (push_val),
        .push_cnt         (push_cnt)
    );

    irpcm_queue #(
        .IDX_BITS      (IW),
        .DURATION_BITS (DURATION_BITS)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_op  (push_op),
        .push_idx (push_idx),
        .push_val (push_val),
        .push_cnt (push_cnt),
        .pop      (pop),
        .pop_op   (pop_op),
        .pop_idx  (pop_idx),
        .pop_val  (pop_val),
        .pop_cnt  (pop_cnt),
        .empty    (q_empty),
        .full     (q_full)
    );

    irpcm_back #(
        .MAX_PULSES    (MAX_PULSES),
        .DURATION_BITS (DURATION_BITS)
    ) u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .q_empty           (q_empty),
        .q_op              (pop_op),
        .q_idx             (pop_idx),
        .q_val             (pop_val),
        .q_cnt             (pop_cnt),
        .q_pop             (pop),
        .tolerance_percent (tolerance_reg),
        .reference_length  (ref_length_reg),
        .out_valid         (m_axis_tvalid),
        .out_ready         (m_axis_tready),
        .out_matched       (out_matched),
        .out_count         (out_count),
        .out_overflowed    (out_overflowed)
    );

    // Result beat packing.
    assign m_axis_tdata = {
        {(OUT_DATA_BITS-COUNT_BITS-2){1'b0}}, out_overflowed, out_count, out_matched
    };

endmodule

`default_nettype wire
